// File: rtl/gbes_pkg.sv
// Shared types, codes and default sizes for the gap buffer edit store.
`timescale 1ns / 1ps
`default_nettype none

package gbes_pkg;

  // Default sizes, handed to the top level parameters
  localparam int CAPACITY_DEF   = 1024;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed field widths of the item channels
  localparam int OP_W     = 2;
  localparam int POS_W    = 11;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  // Input item
  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [POS_W-1:0]          position;
    logic [POS_W-1:0]          range_end;
    logic signed [VALUE_W-1:0] new_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]          element_count;
    logic                      is_empty;
  } out_item_t;

  // Commands from the sequencer to the gap pointer unit
  typedef struct packed {
    logic step;    // move the gap one slot towards the target
    logic insert;  // claim the first gap slot
    logic erase;   // widen the gap over the erased range
  } gap_cmd_t;

endpackage : gbes_pkg

`default_nettype wire

// File: rtl/gbes_slot_ram.sv
// Element store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gbes_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data valid the cycle after the request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : gbes_slot_ram

`default_nettype wire

// File: rtl/gbes_gap_unit.sv
// Gap pointers and element count, with the shared step and address arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module gbes_gap_unit
  import gbes_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gap_cmd_t      cmd_i,
  input  wire logic [CW-1:0] target_i,     // logical position the gap moves to
  input  wire logic [CW-1:0] erase_len_i,
  input  wire logic [CW-1:0] rd_pos_i,     // logical index to look up
  output logic               at_target_o,
  output logic      [AW-1:0] step_raddr_o,
  output logic      [AW-1:0] step_waddr_o,
  output logic      [AW-1:0] ins_addr_o,
  output logic      [AW-1:0] lookup_addr_o,
  output logic      [CW-1:0] count_o,
  output logic      [CW-1:0] gap_start_o,
  output logic      [CW-1:0] gap_stop_o
);

  logic [CW-1:0] gap_start_q, gap_start_d;
  logic [CW-1:0] gap_stop_q, gap_stop_d;
  logic [CW-1:0] count_q, count_d;
  logic          move_left;
  logic [CW-1:0] start_step, stop_step;
  logic [CW-1:0] lookup_slot;

  // Step unit: both pointers move by one in the same direction
  assign move_left   = target_i < gap_start_q;
  assign at_target_o = target_i == gap_start_q;
  assign start_step  = move_left ? gap_start_q - CW'(1) : gap_start_q + CW'(1);
  assign stop_step   = move_left ? gap_stop_q - CW'(1) : gap_stop_q + CW'(1);

  // Moving left copies the slot below the gap to its top end;
  // moving right copies the slot above the gap to its bottom end
  assign step_raddr_o = move_left ? start_step[AW-1:0] : gap_stop_q[AW-1:0];
  assign step_waddr_o = move_left ? stop_step[AW-1:0]  : gap_start_q[AW-1:0];
  assign ins_addr_o   = gap_start_q[AW-1:0];

  // Logical to physical slot
  assign lookup_slot   = (rd_pos_i < gap_start_q) ? rd_pos_i
                                                  : gap_stop_q + (rd_pos_i - gap_start_q);
  assign lookup_addr_o = lookup_slot[AW-1:0];

  // Pointer and count update
  always_comb begin
    gap_start_d = gap_start_q;
    gap_stop_d  = gap_stop_q;
    count_d     = count_q;
    if (cmd_i.step) begin
      gap_start_d = start_step;
      gap_stop_d  = stop_step;
    end else if (cmd_i.insert) begin
      gap_start_d = gap_start_q + CW'(1);
      count_d     = count_q + CW'(1);
    end else if (cmd_i.erase) begin
      gap_stop_d  = gap_stop_q + erase_len_i;
      count_d     = count_q - erase_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_start_q <= '0;
      gap_stop_q  <= CW'(CAPACITY);
      count_q     <= '0;
    end else begin
      gap_start_q <= gap_start_d;
      gap_stop_q  <= gap_stop_d;
      count_q     <= count_d;
    end
  end

  assign count_o     = count_q;
  assign gap_start_o = gap_start_q;
  assign gap_stop_o  = gap_stop_q;

endmodule : gbes_gap_unit

`default_nettype wire

// File: rtl/gap_buffer_edit_store_unit.sv
// Top level of the gap buffer edit store: sequencer, checks and result register.
`timescale 1ns / 1ps
`default_nettype none

// Gap buffer of CAPACITY elements. Each item is an insert, an erase of a
// half-open range or a read, and gives one result. The block takes one item at
// a time: in_ready_o is high only while the sequencer is idle, and a finished
// result waits in the output register without holding up the next item. A
// rejected item (also one with an unknown operation code) goes from the check
// state straight to the result; a read starts its element store read in the
// check state and registers the data before the result. An insert or erase
// first moves the gap by copying one element per cycle through the element
// store (read one cycle, write back the next), d elements in all, where d is
// the distance between the gap and the edit position (at most CAPACITY), and
// then edits the gap pointers. A result waits until the previous one is taken.
// The store needs no clearing after reset; unwritten slots are never read.
module gap_buffer_edit_store_unit
  import gbes_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_EDIT  = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state_q, state_d;
  in_item_t            item_q;
  status_e             status_q, status_d;
  logic [VALUE_W-1:0]  rd_q, rd_d;
  logic [CW-1:0]       len_q, len_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       wa_q, wa_d;
  logic                out_valid_q;
  out_item_t           out_q;

  gap_cmd_t            cmd;
  logic                at_target;
  logic [AW-1:0]       step_raddr, step_waddr, ins_addr, lookup_addr;
  logic [CW-1:0]       count, gap_start, gap_stop;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [CMPW-1:0]     pos_x, end_x, count_x;
  logic [CMPW-1:0]     len_x;
  logic signed [63:0]  val64;
  logic [63:0]         rd64;
  logic                load_out;

  // Widened operands for the range checks
  assign pos_x   = CMPW'(item_q.position);
  assign end_x   = CMPW'(item_q.range_end);
  assign count_x = CMPW'(count);
  assign len_x   = end_x - pos_x;

  // Element width adaptation on the way in and out
  assign val64 = 64'(item_q.new_value);
  assign rd64  = 64'(ram_rdata);

  gbes_gap_unit #(
    .CAPACITY (CAPACITY)
  ) u_gap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .target_i      (pos_x[CW-1:0]),
    .erase_len_i   (len_q),
    .rd_pos_i      (pos_x[CW-1:0]),
    .at_target_o   (at_target),
    .step_raddr_o  (step_raddr),
    .step_waddr_o  (step_waddr),
    .ins_addr_o    (ins_addr),
    .lookup_addr_o (lookup_addr),
    .count_o       (count),
    .gap_start_o   (gap_start),
    .gap_stop_o    (gap_stop)
  );

  gbes_slot_ram #(
    .DEPTH (CAPACITY),
    .DW    (ELEM_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = state_q == S_IDLE;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    rd_d      = rd_q;
    len_d     = len_q;
    pend_d    = 1'b0;
    wa_d      = wa_q;
    cmd       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ins_addr;
    ram_wdata = val64[ELEM_WIDTH-1:0];
    ram_raddr = lookup_addr;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        status_d = STATUS_OK;
        rd_d     = '0;
        unique case (item_q.operation)
          OP_INSERT: begin
            if (pos_x > count_x) begin
              status_d = STATUS_BAD_POS;
              state_d  = S_DONE;
            end else if (count_x == CMPW'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = S_DONE;
            end else begin
              state_d = S_MOVE;
            end
          end
          OP_ERASE: begin
            if ((pos_x > end_x) || (end_x > count_x)) begin
              status_d = STATUS_BAD_POS;
              state_d  = S_DONE;
            end else begin
              len_d   = len_x[CW-1:0];
              state_d = S_MOVE;
            end
          end
          OP_READ: begin
            if (pos_x >= count_x) begin
              status_d = STATUS_BAD_POS;
              rd_d     = '1;
              state_d  = S_DONE;
            end else begin
              ram_re  = 1'b1;
              state_d = S_RDATA;
            end
          end
          default: begin
            status_d = STATUS_BAD_POS;
            state_d  = S_DONE;
          end
        endcase
      end
      S_MOVE: begin
        // Read one slot per cycle, write it back the cycle after
        if (!at_target) begin
          ram_re    = 1'b1;
          ram_raddr = step_raddr;
          cmd.step  = 1'b1;
          pend_d    = 1'b1;
          wa_d      = step_waddr;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wa_q;
          ram_wdata = ram_rdata;
        end
        if (at_target && !pend_q) begin
          state_d = S_EDIT;
        end
      end
      S_EDIT: begin
        if (item_q.operation == OP_INSERT) begin
          ram_we     = 1'b1;
          cmd.insert = 1'b1;
        end else begin
          cmd.erase = 1'b1;
        end
        state_d = S_DONE;
      end
      S_RDATA: begin
        rd_d    = rd64[VALUE_W-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // Item and working payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    status_q <= status_d;
    rd_q     <= rd_d;
    len_q    <= len_d;
    wa_q     <= wa_d;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.status        <= status_q;
      out_q.read_value    <= rd_q;
      out_q.element_count <= count_x[POS_W-1:0];
      out_q.is_empty      <= count == '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks on the sequencer and the gap pointers
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_gap_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gap_stop - gap_start) == (CW'(CAPACITY) - count))
    else $error("gap size does not match free slots");

  a_pend_in_move : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_MOVE))
    else $error("copy write pending outside gap move");

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("finished result not presented");

endmodule : gap_buffer_edit_store_unit

`default_nettype wire

// File: tb/sv/gap_buffer_edit_store_unit_tb.sv
// Self-checking testbench for the gap buffer edit store: random edits checked against a mirror.
`timescale 1ns / 1ps

module gap_buffer_edit_store_unit_tb;
  import gbes_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_EDITS = 365;
  localparam int DRAIN_CYCLES = 1100;     // longest gap move plus overhead
  localparam int CYCLE_LIMIT  = 5000000;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  in_item_t                  edit_requests_q[$];   // items still to be offered
  out_item_t                 edit_outcomes_q[$];   // results owed by the block
  logic signed [VALUE_W-1:0] mirror_elems[$];      // logical contents, index 0 first
  int                        plan_count = 0;       // element count as seen by the generator
  int                        mismatches = 0;
  int                        cycle_cnt  = 0;

  gap_buffer_edit_store_unit #(
    .CAPACITY   (CAP),
    .ELEM_WIDTH (ELEM_WIDTH_DEF)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Clock and a single reset at the start
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle percentage for the three phases: first, second, then none
  function automatic int idle_pct(int n, int first_pct, int second_pct);
    if (n < 140) return first_pct;
    if (n < 280) return second_pct;
    return 0;
  endfunction

  // Apply one edit to the mirror and work out the result the block owes
  function automatic out_item_t apply_edit(in_item_t it);
    out_item_t r;
    int        p;
    int        e;
    r = '0;
    p = it.position;
    e = it.range_end;
    case (it.operation)
      OP_INSERT: begin
        if (p > mirror_elems.size()) r.status = STATUS_BAD_POS;
        else if (mirror_elems.size() >= CAP) r.status = STATUS_FULL;
        else mirror_elems.insert(p, it.new_value);
      end
      OP_ERASE: begin
        if (p > e || e > mirror_elems.size()) r.status = STATUS_BAD_POS;
        else for (int k = p; k < e; k++) mirror_elems.delete(p);
      end
      OP_READ: begin
        if (p >= mirror_elems.size()) begin
          r.status     = STATUS_BAD_POS;
          r.read_value = -1;
        end else begin
          r.read_value = mirror_elems[p];
        end
      end
      default: r.status = STATUS_BAD_POS;
    endcase
    r.element_count = POS_W'(mirror_elems.size());
    r.is_empty      = (mirror_elems.size() == 0);
    return r;
  endfunction

  // Compare one result with the oldest one owed
  task automatic check_outcome(out_item_t got);
    out_item_t want;
    if (edit_outcomes_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %p", $time, got);
      mismatches++;
    end else begin
      want = edit_outcomes_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %0d got %0d", $time, want.read_value,
                 got.read_value);
        mismatches++;
      end
      if (got.element_count !== want.element_count) begin
        $display("%0t: element_count expected %0d got %0d", $time, want.element_count,
                 got.element_count);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $display("%0t: is_empty expected %0b got %0b", $time, want.is_empty, got.is_empty);
        mismatches++;
      end
    end
  endtask

  // Queue one item and track the element count so later items can aim at it
  function automatic void queue_edit(logic [OP_W-1:0] op, int pos, int rend,
                                     logic [VALUE_W-1:0] val);
    in_item_t it;
    it.operation = op;
    it.position  = POS_W'(pos);
    it.range_end = POS_W'(rend);
    it.new_value = val;
    edit_requests_q.push_back(it);
    if (op == OP_INSERT && pos <= plan_count && plan_count < CAP) plan_count++;
    else if (op == OP_ERASE && pos <= rend && rend <= plan_count) plan_count -= rend - pos;
  endfunction

  // Element value, extremes now and then
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Driver: offers queued items, holds each until taken
  int launched = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      launched   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (edit_requests_q.size() != 0 && $urandom_range(99) >= idle_pct(launched, 13, 59)) begin
        in_item_i  <= edit_requests_q.pop_front();
        in_valid_i <= 1'b1;
        launched   <= launched + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  int drained   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      drained     <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) drained <= drained + 1;
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && drained == 40) begin
        hold_left   <= 400;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct(drained, 59, 13));
      end
    end
  end

  // Monitor: check results first, then predict for the item taken this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_outcome(out_item_o);
      if (in_valid_i && in_ready_o) edit_outcomes_q.push_back(apply_edit(in_item_i));
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int pick;
    int p;
    int e;
    int span;

    // Directed: empty store, extremes of value and position, bad ranges
    queue_edit(OP_READ, 0, 0, 0);
    queue_edit(OP_ERASE, 0, 0, 0);
    queue_edit(OP_INSERT, 1, 0, 7);
    queue_edit(OP_INSERT, 0, 0, 32'h7FFF_FFFF);
    queue_edit(OP_INSERT, 0, 0, 32'h8000_0000);
    queue_edit(OP_INSERT, 2, 2047, 32'hFFFF_FFFF);
    queue_edit(OP_INSERT, 1, 0, 32'h0);
    queue_edit(OP_INSERT, 4, 0, 32'h5A5A_5A5A);
    for (int k = 0; k < 5; k++) queue_edit(OP_READ, k, 2047, 32'hFFFF_FFFF);
    queue_edit(OP_READ, 5, 0, 0);
    queue_edit(OP_READ, 2047, 0, 0);
    queue_edit(OP_ERASE, 3, 2, 0);
    queue_edit(OP_ERASE, 0, 6, 0);
    queue_edit(OP_ERASE, 2, 2, 0);               // empty range, gap still moves
    queue_edit(OP_ERASE, 1, 3, 32'hFFFF_FFFF);
    queue_edit(OP_UNKNOWN, 2047, 2047, 32'hFFFF_FFFF);
    queue_edit(OP_INSERT, 2047, 0, 1);
    queue_edit(OP_ERASE, 2047, 2047, 0);
    queue_edit(OP_READ, 1, 0, 0);
    queue_edit(OP_INSERT, 3, 0, 32'h1234_5678);
    queue_edit(OP_ERASE, 0, 4, 0);
    queue_edit(OP_READ, 0, 0, 0);

    // Random: mostly well-formed edits on a small store, some noise and bad ranges
    for (int n = 0; n < RANDOM_EDITS; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_edit(OP_W'($urandom_range(3)), $urandom_range(2047), $urandom_range(2047),
                   $urandom);
      end else if (pick < 45 && plan_count < 48) begin
        if ($urandom_range(9) == 0) p = plan_count + 1 + $urandom_range(3);
        else p = $urandom_range(plan_count);
        queue_edit(OP_INSERT, p, $urandom_range(2047), pick_value());
      end else if (pick < 70) begin
        p    = $urandom_range(plan_count);
        span = plan_count - p;
        if (span > ((plan_count >= 48) ? 16 : 6)) span = (plan_count >= 48) ? 16 : 6;
        e    = p + $urandom_range(span);
        if ($urandom_range(9) == 0) e = (p > 0) ? p - 1 : plan_count + 1;
        queue_edit(OP_ERASE, p, e, $urandom);
      end else begin
        if (plan_count == 0 || $urandom_range(9) == 0) p = plan_count + $urandom_range(2);
        else p = $urandom_range(plan_count - 1);
        queue_edit(OP_READ, p, $urandom_range(2047), $urandom);
      end
    end

    // Ends of the store, positions past capacity, then clear everything
    queue_edit(OP_INSERT, 0, 0, pick_value());
    queue_edit(OP_INSERT, plan_count, 0, pick_value());
    queue_edit(OP_INSERT, CAP, 0, 2);
    queue_edit(OP_INSERT, CAP + 1, 0, 3);
    queue_edit(OP_READ, plan_count - 1, 0, 0);
    queue_edit(OP_READ, 0, 0, 0);
    queue_edit(OP_READ, CAP, 0, 0);
    queue_edit(OP_ERASE, 0, plan_count, 0);
    queue_edit(OP_READ, 0, 0, 0);

    // Wait for every item to be taken and every result to arrive
    @(posedge rst_ni);
    while (edit_requests_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (edit_outcomes_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: gap_buffer_edit_store_unit.f
rtl/gbes_pkg.sv
rtl/gbes_slot_ram.sv
rtl/gbes_gap_unit.sv
rtl/gap_buffer_edit_store_unit.sv
tb/sv/gap_buffer_edit_store_unit_tb.sv
